// ===== sv/pmp_pkg.sv =====
`default_nettype none
package pmp_pkg;

    localparam int MAX_STATES = 16;
    localparam int MAX_PERIOD = 64;

    localparam int N_W      = $clog2(MAX_STATES);
    localparam int N_CNT_W  = $clog2(MAX_STATES + 1);
    localparam int P_W      = $clog2(MAX_PERIOD);
    localparam int P_CNT_W  = $clog2(MAX_PERIOD + 1);
    localparam int ADDR_W   = P_W + 2 * N_W;

    localparam int Q_W      = 32;
    localparam int STEP_W   = 16;
    localparam int SUM_W    = Q_W + 2;
    localparam int PROD_W   = 2 * Q_W;
    localparam int FRAC_W   = 31;

    localparam logic [Q_W-1:0] Q_ONE = 32'h8000_0000;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (4 + Q_W + STEP_W);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_STATES_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD_MATRIX = 2'd0,
        OP_LOAD_VECTOR = 2'd1,
        OP_STEP        = 2'd2
    } pmp_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT,
        ST_MAC,
        ST_DRAIN,
        ST_COMMIT
    } pmp_state_t;

    typedef struct packed {
        logic           load_mtx;
        logic           load_vec;
        logic           emit;
        logic           mac;
        logic           first;
        logic           last;
        logic           commit;
        logic [N_W-1:0] row;
        logic [N_W-1:0] col;
    } pmp_cmd_t;

    typedef struct packed {
        logic [N_W-1:0] n_m1;
        logic           out_free;
        logic           pipe_busy;
    } pmp_status_t;

    function automatic logic [Q_W-1:0] sat_q(input logic [SUM_W-1:0] v);
        logic [Q_W-1:0] r;
        if (v > SUM_W'(Q_ONE)) begin
            r = Q_ONE;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/pmp_ctrl.sv =====
`default_nettype none
module pmp_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire pmp_pkg::pmp_op_t     s_op,
    input  wire pmp_pkg::pmp_status_t status,
    output pmp_pkg::pmp_cmd_t         cmd
);

    pmp_pkg::pmp_state_t           state_reg, state_next;
    logic [pmp_pkg::N_W-1:0]       row_reg, row_next;
    logic [pmp_pkg::N_W-1:0]       col_reg, col_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pmp_pkg::ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.row    = row_reg;
        cmd.col    = col_reg;
        unique case (state_reg)
            pmp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (s_op)
                        pmp_pkg::OP_LOAD_MATRIX: cmd.load_mtx = 1'b1;
                        pmp_pkg::OP_LOAD_VECTOR: cmd.load_vec = 1'b1;
                        pmp_pkg::OP_STEP: begin
                            row_next   = '0;
                            col_next   = '0;
                            state_next = pmp_pkg::ST_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            pmp_pkg::ST_EMIT: begin
                cmd.last = (row_reg == status.n_m1);
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (row_reg == status.n_m1) begin
                        row_next   = '0;
                        state_next = pmp_pkg::ST_MAC;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            pmp_pkg::ST_MAC: begin
                cmd.mac   = 1'b1;
                cmd.first = (col_reg == '0);
                cmd.last  = (col_reg == status.n_m1);
                if (col_reg == status.n_m1) begin
                    col_next = '0;
                    if (row_reg == status.n_m1) begin
                        row_next   = '0;
                        state_next = pmp_pkg::ST_DRAIN;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            pmp_pkg::ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = pmp_pkg::ST_COMMIT;
                end
            end
            pmp_pkg::ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = pmp_pkg::ST_IDLE;
            end
            default: state_next = pmp_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/pmp_datapath.sv =====
`default_nettype none
module pmp_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire pmp_pkg::pmp_cmd_t                 cmd,
    output pmp_pkg::pmp_status_t                   status,
    input  wire logic [pmp_pkg::P_W-1:0]           s_slot,
    input  wire logic [pmp_pkg::N_W-1:0]           s_row,
    input  wire logic [pmp_pkg::N_W-1:0]           s_col,
    input  wire logic [pmp_pkg::Q_W-1:0]           s_value,
    input  wire logic                              cfg_valid,
    input  wire logic [pmp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pmp_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [pmp_pkg::N_W-1:0]                m_state,
    output logic [pmp_pkg::Q_W-1:0]                m_prob,
    output logic [pmp_pkg::STEP_W-1:0]             m_step,
    output logic                                   m_last
);

    logic [pmp_pkg::N_CNT_W-1:0] states_reg;
    logic [pmp_pkg::P_CNT_W-1:0] period_reg;
    logic [pmp_pkg::N_CNT_W-1:0] n_used;
    logic [pmp_pkg::P_CNT_W-1:0] p_used;

    logic [pmp_pkg::P_W-1:0]     phase_reg;
    logic [pmp_pkg::STEP_W-1:0]  step_reg;
    logic [pmp_pkg::P_CNT_W-1:0] phase_inc;

    logic [pmp_pkg::Q_W-1:0] mtx_mem [2**pmp_pkg::ADDR_W];
    logic [pmp_pkg::Q_W-1:0] vec_reg [pmp_pkg::MAX_STATES];
    logic [pmp_pkg::Q_W-1:0] nxt_reg [pmp_pkg::MAX_STATES];
    logic [pmp_pkg::Q_W-1:0] in_sat;
    logic [pmp_pkg::N_W-1:0] vec_addr;

    logic [pmp_pkg::Q_W-1:0]    mtx_rd_reg;
    logic [pmp_pkg::Q_W-1:0]    vec_rd_reg;
    logic                       s1_valid_reg, s1_first_reg, s1_last_reg;
    logic [pmp_pkg::N_W-1:0]    s1_row_reg;
    logic [pmp_pkg::PROD_W-1:0] prod_reg;
    logic                       s2_valid_reg, s2_first_reg, s2_last_reg;
    logic [pmp_pkg::N_W-1:0]    s2_row_reg;
    logic [pmp_pkg::Q_W-1:0]    acc_reg;
    logic [pmp_pkg::SUM_W-1:0]  acc_sum;
    logic [pmp_pkg::Q_W-1:0]    acc_next;

    logic m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            states_reg <= pmp_pkg::N_CNT_W'(pmp_pkg::MAX_STATES);
            period_reg <= pmp_pkg::P_CNT_W'(40);
        end else if (cfg_valid) begin
            if (cfg_index == pmp_pkg::CFG_STATES_IN_USE) begin
                states_reg <= cfg_data[pmp_pkg::N_CNT_W-1:0];
            end else begin
                period_reg <= cfg_data[pmp_pkg::P_CNT_W-1:0];
            end
        end
    end

    always_comb begin
        if (states_reg == '0) begin
            n_used = pmp_pkg::N_CNT_W'(1);
        end else if (states_reg > pmp_pkg::N_CNT_W'(pmp_pkg::MAX_STATES)) begin
            n_used = pmp_pkg::N_CNT_W'(pmp_pkg::MAX_STATES);
        end else begin
            n_used = states_reg;
        end
        if (period_reg == '0) begin
            p_used = pmp_pkg::P_CNT_W'(1);
        end else if (period_reg > pmp_pkg::P_CNT_W'(pmp_pkg::MAX_PERIOD)) begin
            p_used = pmp_pkg::P_CNT_W'(pmp_pkg::MAX_PERIOD);
        end else begin
            p_used = period_reg;
        end
    end

    assign phase_inc = pmp_pkg::P_CNT_W'(phase_reg) + 1'b1;
    assign in_sat    = pmp_pkg::sat_q(pmp_pkg::SUM_W'(s_value));
    assign vec_addr  = cmd.emit ? cmd.row : cmd.col;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            step_reg  <= '0;
        end else if (cmd.commit) begin
            phase_reg <= (phase_inc >= p_used) ? '0 : phase_inc[pmp_pkg::P_W-1:0];
            step_reg  <= step_reg + 1'b1;
        end
    end

    // transition matrices, one word per {slot, row, column}
    always_ff @(posedge aclk) begin
        if (cmd.load_mtx) begin
            mtx_mem[{s_slot, s_row, s_col}] <= in_sat;
        end
        mtx_rd_reg <= mtx_mem[{phase_reg, cmd.row, cmd.col}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < pmp_pkg::MAX_STATES; k++) begin
                vec_reg[k] <= '0;
            end
        end else if (cmd.load_vec) begin
            vec_reg[s_row] <= in_sat;
        end else if (cmd.commit) begin
            for (int k = 0; k < pmp_pkg::MAX_STATES; k++) begin
                if (pmp_pkg::N_CNT_W'(k) < n_used) begin
                    vec_reg[k] <= nxt_reg[k];
                end
            end
        end
    end

    // MAC pipeline: read, multiply, accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.mac;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        vec_rd_reg   <= vec_reg[vec_addr];
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last;
        s1_row_reg   <= cmd.row;
        prod_reg     <= pmp_pkg::PROD_W'(mtx_rd_reg) * pmp_pkg::PROD_W'(vec_rd_reg);
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_row_reg   <= s1_row_reg;
    end

    assign acc_sum  = (s2_first_reg ? '0 : pmp_pkg::SUM_W'(acc_reg))
                    + pmp_pkg::SUM_W'(prod_reg[pmp_pkg::PROD_W-1:pmp_pkg::FRAC_W]);
    assign acc_next = pmp_pkg::sat_q(acc_sum);

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            acc_reg <= acc_next;
            if (s2_last_reg) begin
                nxt_reg[s2_row_reg] <= acc_next;
            end
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_state <= cmd.row;
            m_prob  <= vec_reg[vec_addr];
            m_step  <= step_reg;
            m_last  <= cmd.last;
        end
    end

    assign m_tvalid         = m_tvalid_reg;
    assign status.n_m1      = pmp_pkg::N_W'(n_used - 1'b1);
    assign status.out_free  = !m_tvalid_reg || m_tready;
    assign status.pipe_busy = s1_valid_reg || s2_valid_reg;

`ifndef SYNTHESIS
    a_commit_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !s1_valid_reg && !s2_valid_reg)
        else $error("commit with MAC pipeline busy");
    a_emit_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !m_tvalid_reg || m_tready)
        else $error("output word overwritten");
    a_mac_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mac |-> !cmd.load_mtx && !cmd.load_vec && !cmd.emit && !cmd.commit)
        else $error("MAC overlaps another command");
    a_step_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> step_reg == $past(step_reg) + 1'b1)
        else $error("step count not advanced");
`endif

endmodule
`default_nettype wire

// ===== sv/periodic_markov_propagator.sv =====
`default_nettype none
// Markov propagator over a bank of up to 64 Q1.31 transition matrices (16 states max).
// Load words (operation 0/1) each write one matrix entry or one vector entry.
// A step word (operation 2) first sends the current vector, one output word per state in use,
// tlast on the last, then computes the next vector with a single shared 32x32 MAC,
// which does one multiply-accumulate per cycle from the matrix memory; the MAC pipeline
// then drains and a commit writes the new vector. Output stalls lengthen the output phase.
// Products truncate, row sums saturate at 1.0. Config writes are accepted every cycle and
// must be issued only between steps, with nothing in flight.
module periodic_markov_propagator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // operation[1:0], slot[7:2], row[11:8], column[15:12], value[47:16]
    input  wire logic [pmp_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // state_number[3:0], probability[35:4], step_number[51:36], zero pad[55:52]
    output logic [pmp_pkg::OUT_TDATA_W-1:0]          m_tdata,
    output logic                                     m_tlast,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pmp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [pmp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    pmp_pkg::pmp_cmd_t              cmd;
    pmp_pkg::pmp_status_t           status;
    pmp_pkg::pmp_op_t               s_op;
    logic [pmp_pkg::N_W-1:0]        m_state;
    logic [pmp_pkg::Q_W-1:0]        m_prob;
    logic [pmp_pkg::STEP_W-1:0]     m_step;

    assign s_op      = pmp_pkg::pmp_op_t'(s_tdata[1:0]);
    assign cfg_ready = 1'b1;
    assign m_tdata   = {{pmp_pkg::OUT_PAD_W{1'b0}}, m_step, m_prob, m_state};

    pmp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_op),
        .status   (status),
        .cmd      (cmd)
    );

    pmp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_slot    (s_tdata[7:2]),
        .s_row     (s_tdata[11:8]),
        .s_col     (s_tdata[15:12]),
        .s_value   (s_tdata[47:16]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_state   (m_state),
        .m_prob    (m_prob),
        .m_step    (m_step),
        .m_last    (m_tlast)
    );

endmodule
`default_nettype wire
